/* src/geo_distance_haversine_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the great-circle distance unit
// Concurrent assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GEO_DISTANCE_HAVERSINE_UNIT_DEFINES_SVH
`define GEO_DISTANCE_HAVERSINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GHU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define GHU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define GHU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GHU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/ghu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Great-circle distance unit package
// Shared widths, fixed-point constants, register indexes and the arctangent
// table used by the CORDIC stages.
// ----------------------------------------------------------------------------
package ghu_pkg;

   localparam int THETA_W      = 35;
   localparam int TRIG_W       = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int SC_LAT       = CORDIC_STEPS + 4;
   localparam int ROOT_IN_W    = 61;
   localparam int ROOT_STEPS   = (ROOT_IN_W + 1) / 2;
   localparam int ROOT_OUT_W   = 31;
   localparam int ROOT_LAT     = ROOT_STEPS + 1;
   localparam int SHORT_W      = 26;
   localparam int RADIUS_W     = 23;
   localparam int LIMIT_W      = 24;
   localparam int DIST_W       = 35;
   localparam int CSR_INDEX_W  = 2;

   typedef logic signed [THETA_W-1:0] theta_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EARTH_RADIUS = 2'd0,
      CSR_SHORT_LIMIT  = 2'd1
   } csr_index_type;

   localparam logic [30:0]          UNIT_TO_RAD_Q60 = 31'd2012227627;
   localparam theta_type            PI_Q30          = 35'sd3373259426;
   localparam theta_type            TWO_PI_Q30      = 35'sd6746518852;
   localparam theta_type            HALF_PI_Q30     = 35'sd1686629713;
   localparam trig_type             CORDIC_GAIN_INV = 34'sh026DD3B6A;
   localparam logic [30:0]          ONE_Q30         = 31'h4000_0000;
   localparam logic [RADIUS_W-1:0]  RADIUS_RESET    = 23'd6371000;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 24'd1000000;

   function automatic trig_type arc_entry(input int unsigned idx);
      trig_type r;
      case (idx)
         0:  r = 34'sh03243F6A8;
         1:  r = 34'sh01DAC6705;
         2:  r = 34'sh00FADBAFC;
         3:  r = 34'sh007F56EA6;
         4:  r = 34'sh003FEAB76;
         5:  r = 34'sh001FFD55B;
         6:  r = 34'sh000FFFAAA;
         7:  r = 34'sh0007FFF55;
         8:  r = 34'sh0003FFFEA;
         9:  r = 34'sh0001FFFFD;
         10: r = 34'sh0000FFFFF;
         11: r = 34'sh00007FFFF;
         12: r = 34'sh00003FFFF;
         13: r = 34'sh00001FFFF;
         14: r = 34'sh00000FFFF;
         15: r = 34'sh000007FFF;
         16: r = 34'sh000003FFF;
         17: r = 34'sh000001FFF;
         18: r = 34'sh000000FFF;
         19: r = 34'sh0000007FF;
         20: r = 34'sh0000003FF;
         21: r = 34'sh0000001FF;
         22: r = 34'sh0000000FF;
         23: r = 34'sh00000007F;
         24: r = 34'sh00000003F;
         25: r = 34'sh00000001F;
         26: r = 34'sh00000000F;
         27: r = 34'sh000000008;
         28: r = 34'sh000000004;
         29: r = 34'sh000000002;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* src/ghu_sincos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Reduces a Q30 radian angle into the right half plane, then runs one
// rotation CORDIC step per register stage.
// ----------------------------------------------------------------------------
module ghu_sincos (
   input  logic               clock,
   input  logic               en,
   input  ghu_pkg::theta_type theta,
   output ghu_pkg::trig_type  sin_out,
   output ghu_pkg::trig_type  cos_out
);

   localparam int STEPS = ghu_pkg::CORDIC_STEPS;
   localparam int TW    = ghu_pkg::TRIG_W;

   ghu_pkg::theta_type th1_ff;
   ghu_pkg::theta_type th2_ff;
   ghu_pkg::trig_type  x_ff [STEPS+1];
   ghu_pkg::trig_type  y_ff [STEPS+1];
   ghu_pkg::trig_type  z_ff [STEPS+1];
   logic [STEPS:0]     flip_ff;
   ghu_pkg::trig_type  sin_ff;
   ghu_pkg::trig_type  cos_ff;

   function automatic ghu_pkg::theta_type reduce_turn(input ghu_pkg::theta_type t);
      ghu_pkg::theta_type r;
      r = t;
      if (r > ghu_pkg::PI_Q30) r = r - ghu_pkg::TWO_PI_Q30;
      if (r < -ghu_pkg::PI_Q30) r = r + ghu_pkg::TWO_PI_Q30;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         th1_ff <= reduce_turn(theta);
         th2_ff <= reduce_turn(th1_ff);
         x_ff[0] <= ghu_pkg::CORDIC_GAIN_INV;
         y_ff[0] <= '0;
         if (th2_ff > ghu_pkg::HALF_PI_Q30) begin
            z_ff[0]    <= TW'(th2_ff - ghu_pkg::PI_Q30);
            flip_ff[0] <= 1'b1;
         end else if (th2_ff < -ghu_pkg::HALF_PI_Q30) begin
            z_ff[0]    <= TW'(th2_ff + ghu_pkg::PI_Q30);
            flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0]    <= TW'(th2_ff);
            flip_ff[0] <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][TW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ghu_pkg::arc_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ghu_pkg::arc_entry(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
         cos_ff <= flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

/* src/ghu_root.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with a
// final stage that rounds to nearest.
// ----------------------------------------------------------------------------
module ghu_root (
   input  logic                               clock,
   input  logic                               en,
   input  logic [ghu_pkg::ROOT_IN_W-1:0]      n,
   output logic [ghu_pkg::ROOT_OUT_W-1:0]     root
);

   localparam int RW    = ghu_pkg::ROOT_IN_W + 1;
   localparam int STEPS = ghu_pkg::ROOT_STEPS;

   logic [RW-1:0]                   rem_ff [STEPS];
   logic [RW-1:0]                   res_ff [STEPS];
   logic [ghu_pkg::ROOT_OUT_W-1:0]  root_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (ghu_pkg::ROOT_IN_W - 1 - 2 * k);
      logic [RW-1:0] rem_src;
      logic [RW-1:0] res_src;
      logic [RW-1:0] trial;
      if (k == 0) begin : g_first
         assign rem_src = RW'(n);
         assign res_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign res_src = res_ff[k-1];
      end
      assign trial = res_src + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_src >= trial) begin
               rem_ff[k] <= rem_src - trial;
               res_ff[k] <= (res_src >> 1) + BIT;
            end else begin
               rem_ff[k] <= rem_src;
               res_ff[k] <= res_src >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (rem_ff[STEPS-1] > res_ff[STEPS-1]) begin
            root_ff <= ghu_pkg::ROOT_OUT_W'(res_ff[STEPS-1] + RW'(1));
         end else begin
            root_ff <= ghu_pkg::ROOT_OUT_W'(res_ff[STEPS-1]);
         end
      end
   end

   assign root = root_ff;

endmodule

/* src/geo_distance_haversine_unit.sv */
`timescale 1ns / 1ps
`include "geo_distance_haversine_unit_defines.svh"
// ----------------------------------------------------------------------------
// Great-circle distance unit
// Distance in millimeters between two latitude/longitude points, by the
// equirectangular form for short deltas and by haversine otherwise.
// ----------------------------------------------------------------------------
// The unit takes one point pair per clock cycle while the pipeline does not
// hold. A result reaches the output register through a chain of 104 register
// stages: 3 stages of degree-to-radian conversion, the 34-stage sine/cosine
// CORDIC, 3 product stages, the 32-stage square root, the 30-stage vectoring
// CORDIC for the arctangent, the scaling by the radius and the output
// register. Empty stages close up while a result waits in the output
// register; the whole pipeline holds only when that register is full,
// not taken, and the last stage is occupied.
module geo_distance_haversine_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [30:0]                 req_lat_a,
   input  logic signed [31:0]                 req_lon_a,
   input  logic signed [30:0]                 req_lat_b,
   input  logic signed [31:0]                 req_lon_b,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ghu_pkg::DIST_W-1:0]         rsp_distance_mm,
   output logic                               rsp_short_form_used,
   input  logic                               csr_we,
   input  logic [ghu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ghu_pkg::LIMIT_W-1:0]        csr_wdata
);

   localparam int TW       = ghu_pkg::TRIG_W;
   localparam int SW       = ghu_pkg::SHORT_W;
   localparam int RIW      = ghu_pkg::ROOT_IN_W;
   localparam int ROW      = ghu_pkg::ROOT_OUT_W;
   localparam int STEPS    = ghu_pkg::CORDIC_STEPS;
   localparam int ANG_W    = 32;
   localparam int T_W      = ghu_pkg::RADIUS_W + ANG_W;
   localparam int ST_C     = 2;
   localparam int ST_SC    = ST_C + ghu_pkg::SC_LAT;
   localparam int ST_P3    = ST_SC + 3;
   localparam int ST_ROOT  = ST_P3 + ghu_pkg::ROOT_LAT;
   localparam int ST_ATAN  = ST_ROOT + STEPS;
   localparam int ST_T     = ST_ATAN + 1;
   localparam int LAT      = ST_T + 1;
   localparam int MI_MEAN  = 0;
   localparam int MI_DLAT  = 1;
   localparam int MI_DLON  = 2;
   localparam int MI_LA    = 3;
   localparam int MI_LB    = 4;
   localparam int NMAG     = 5;
   localparam int NSC      = 4;
   localparam logic [9:0] MM_PER_M = 10'd1000;

   logic [ghu_pkg::RADIUS_W-1:0] radius_ff;
   logic [ghu_pkg::LIMIT_W-1:0]  limit_ff;

   logic                pipe_en;
   logic                rsp_load;
   logic [LAT-1:0]      valid_ff;
   logic [LAT-1:0]      valid_in;
   logic [LAT-1:0]      short_ff;
   logic                short_a;

   logic signed [31:0]  sum_ll;
   logic signed [31:0]  dlat;
   logic signed [32:0]  dlon;
   logic [32:0]         mag_a [NMAG];
   logic [32:0]         mag_ff [NMAG];
   logic [NMAG-1:0]     neg_ff;
   logic [63:0]         prod_ff [NMAG];
   logic [NMAG-1:0]     neg_b_ff;

   ghu_pkg::theta_type  sc_theta_ff [NSC];
   ghu_pkg::trig_type   sc_sin [NSC];
   ghu_pkg::trig_type   sc_cos [NSC];
   logic signed [SW-1:0] sx_dly_ff [ghu_pkg::SC_LAT+1];
   logic signed [SW-1:0] sy_dly_ff [ghu_pkg::SC_LAT+1];

   logic signed [SW-1:0] short_x_ff;
   logic signed [SW-1:0] short_y_ff;
   ghu_pkg::trig_type   m1_ff;
   ghu_pkg::trig_type   m2_ff;
   ghu_pkg::trig_type   m3_ff;
   logic [2*SW-1:0]     xx_ff;
   logic [2*SW-1:0]     yy_ff;
   ghu_pkg::trig_type   m1d_ff;
   ghu_pkg::trig_type   m4_ff;
   logic signed [TW:0]  a_sum;
   logic [30:0]         a_clamp;
   logic [RIW-1:0]      root_n0_ff;
   logic [RIW-1:0]      root_n1_ff;
   logic [ROW-1:0]      root0;
   logic [ROW-1:0]      root1;

   ghu_pkg::trig_type   ax_ff [STEPS];
   ghu_pkg::trig_type   ay_ff [STEPS];
   ghu_pkg::trig_type   az_ff [STEPS];
   logic [ROW-1:0]      sa_dly_ff [STEPS];

   logic signed [TW:0]  twice_az;
   logic [ANG_W-1:0]    angle;
   logic [T_W-1:0]      t_ff;
   logic [34:0]         mm_whole;
   logic [40:0]         mm_frac;
   logic [ghu_pkg::DIST_W-1:0] mm_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [ghu_pkg::DIST_W-1:0] rsp_dist_ff;
   logic                rsp_short_ff;

   function automatic logic [32:0] mag33(input logic signed [33:0] v);
      return 33'(v[33] ? -v : v);
   endfunction

   function automatic ghu_pkg::theta_type to_rad(input logic [63:0] p, input logic neg,
                                                  input logic half);
      logic [64:0] s;
      logic [33:0] r;
      s = half ? (65'(p) + (65'(1) << 30)) : (65'(p) + (65'(1) << 29));
      r = half ? 34'(s >> 31) : 34'(s >> 30);
      return neg ? -ghu_pkg::theta_type'({1'b0, r}) : ghu_pkg::theta_type'({1'b0, r});
   endfunction

   function automatic ghu_pkg::trig_type mul_q30(input ghu_pkg::trig_type a,
                                                 input ghu_pkg::trig_type b);
      logic signed [2*TW-1:0] p;
      p = (2*TW)'(a) * (2*TW)'(b) + ((2*TW)'(1) <<< 29);
      return TW'(p >>> 30);
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ghu_pkg::RADIUS_RESET;
         limit_ff  <= ghu_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ghu_pkg::CSR_EARTH_RADIUS: radius_ff <= csr_wdata[ghu_pkg::RADIUS_W-1:0];
            ghu_pkg::CSR_SHORT_LIMIT:  limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Flow control.
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign pipe_en   = rsp_load || !valid_ff[LAT-1];
   assign req_ready = pipe_en;
   assign valid_in  = {valid_ff[LAT-2:0], req_valid && pipe_en};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         short_ff <= {short_ff[LAT-2:0], short_a};
      end
   end

   // Stage A: deltas, magnitudes and the choice of form.
   assign sum_ll = 32'(req_lat_a) + 32'(req_lat_b);
   assign dlat   = 32'(req_lat_b) - 32'(req_lat_a);
   assign dlon   = 33'(req_lon_b) - 33'(req_lon_a);

   assign mag_a[MI_MEAN] = mag33(34'(sum_ll));
   assign mag_a[MI_DLAT] = mag33(34'(dlat));
   assign mag_a[MI_DLON] = mag33(34'(dlon));
   assign mag_a[MI_LA]   = mag33(34'(req_lat_a));
   assign mag_a[MI_LB]   = mag33(34'(req_lat_b));

   assign short_a = (mag_a[MI_DLAT] < 33'(limit_ff)) && (mag_a[MI_DLON] < 33'(limit_ff));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < NMAG; i++) begin
            mag_ff[i] <= mag_a[i];
         end
         neg_ff[MI_MEAN] <= sum_ll[31];
         neg_ff[MI_DLAT] <= dlat[31];
         neg_ff[MI_DLON] <= dlon[32];
         neg_ff[MI_LA]   <= req_lat_a[30];
         neg_ff[MI_LB]   <= req_lat_b[30];
      end
   end

   // Stage B: scale to radians.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < NMAG; i++) begin
            prod_ff[i] <= 64'(mag_ff[i]) * 64'(ghu_pkg::UNIT_TO_RAD_Q60);
         end
         neg_b_ff <= neg_ff;
      end
   end

   // Stage C: round to Q30 angles and pick the angles for the sine units.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sc_theta_ff[0] <= short_ff[ST_C-1]
                           ? to_rad(prod_ff[MI_MEAN], neg_b_ff[MI_MEAN], 1'b1)
                           : to_rad(prod_ff[MI_DLAT], neg_b_ff[MI_DLAT], 1'b1);
         sc_theta_ff[1] <= to_rad(prod_ff[MI_DLON], neg_b_ff[MI_DLON], 1'b1);
         sc_theta_ff[2] <= to_rad(prod_ff[MI_LA], neg_b_ff[MI_LA], 1'b0);
         sc_theta_ff[3] <= to_rad(prod_ff[MI_LB], neg_b_ff[MI_LB], 1'b0);
         sx_dly_ff[0]   <= SW'(to_rad(prod_ff[MI_DLON], neg_b_ff[MI_DLON], 1'b0));
         sy_dly_ff[0]   <= SW'(to_rad(prod_ff[MI_DLAT], neg_b_ff[MI_DLAT], 1'b0));
         for (int i = 1; i <= ghu_pkg::SC_LAT; i++) begin
            sx_dly_ff[i] <= sx_dly_ff[i-1];
            sy_dly_ff[i] <= sy_dly_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < NSC; g++) begin : g_sc
      ghu_sincos u_sincos (
         .clock   (clock),
         .en      (pipe_en),
         .theta   (sc_theta_ff[g]),
         .sin_out (sc_sin[g]),
         .cos_out (sc_cos[g])
      );
   end

   // Product stages.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         short_x_ff <= SW'(mul_q30(TW'(sx_dly_ff[ghu_pkg::SC_LAT]), sc_cos[0]));
         short_y_ff <= sy_dly_ff[ghu_pkg::SC_LAT];
         m1_ff      <= mul_q30(sc_sin[0], sc_sin[0]);
         m2_ff      <= mul_q30(sc_cos[2], sc_cos[3]);
         m3_ff      <= mul_q30(sc_sin[1], sc_sin[1]);
         xx_ff      <= unsigned'((2*SW)'(short_x_ff) * (2*SW)'(short_x_ff));
         yy_ff      <= unsigned'((2*SW)'(short_y_ff) * (2*SW)'(short_y_ff));
         m1d_ff     <= m1_ff;
         m4_ff      <= mul_q30(m2_ff, m3_ff);
      end
   end

   assign a_sum = (TW+1)'(m1d_ff) + (TW+1)'(m4_ff);

   always_comb begin
      if (a_sum[TW]) begin
         a_clamp = '0;
      end else if (a_sum > (TW+1)'(ghu_pkg::ONE_Q30)) begin
         a_clamp = ghu_pkg::ONE_Q30;
      end else begin
         a_clamp = a_sum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         root_n0_ff <= short_ff[ST_P3-1] ? (RIW'(xx_ff) + RIW'(yy_ff)) : {a_clamp, 30'b0};
         root_n1_ff <= {ghu_pkg::ONE_Q30 - a_clamp, 30'b0};
      end
   end

   ghu_root u_root0 (
      .clock (clock),
      .en    (pipe_en),
      .n     (root_n0_ff),
      .root  (root0)
   );

   ghu_root u_root1 (
      .clock (clock),
      .en    (pipe_en),
      .n     (root_n1_ff),
      .root  (root1)
   );

   // Vectoring CORDIC for the arctangent, with the short-form angle alongside.
   for (genvar i = 0; i < STEPS; i++) begin : g_atan
      ghu_pkg::trig_type x_src;
      ghu_pkg::trig_type y_src;
      ghu_pkg::trig_type z_src;
      if (i == 0) begin : g_first
         assign x_src = TW'(root1);
         assign y_src = TW'(root0);
         assign z_src = '0;
      end else begin : g_next
         assign x_src = ax_ff[i-1];
         assign y_src = ay_ff[i-1];
         assign z_src = az_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            if (y_src > 0) begin
               ax_ff[i] <= x_src + (y_src >>> i);
               ay_ff[i] <= y_src - (x_src >>> i);
               az_ff[i] <= z_src + ghu_pkg::arc_entry(i);
            end else begin
               ax_ff[i] <= x_src - (y_src >>> i);
               ay_ff[i] <= y_src + (x_src >>> i);
               az_ff[i] <= z_src - ghu_pkg::arc_entry(i);
            end
            sa_dly_ff[i] <= (i == 0) ? root0 : sa_dly_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // Scale by the radius.
   assign twice_az = (TW+1)'(az_ff[STEPS-1]) <<< 1;

   always_comb begin
      if (short_ff[ST_ATAN]) begin
         angle = ANG_W'(sa_dly_ff[STEPS-1]);
      end else if (twice_az[TW]) begin
         angle = '0;
      end else begin
         angle = ANG_W'(twice_az);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t_ff <= T_W'(radius_ff) * T_W'(angle);
      end
   end

   assign mm_whole = 35'(t_ff[T_W-1:30]) * 35'(MM_PER_M);
   assign mm_frac  = 41'(t_ff[29:0]) * 41'(MM_PER_M) + (41'(1) << 29);
   assign mm_in    = ghu_pkg::DIST_W'(mm_whole + 35'(mm_frac[40:30]));

   // Output register.
   assign rsp_valid_in = rsp_load ? valid_ff[LAT-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_dist_ff  <= mm_in;
         rsp_short_ff <= short_ff[ST_T];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance_mm     = rsp_dist_ff;
   assign rsp_short_form_used = rsp_short_ff;

   `GHU_ASSERT_IMPL(a_stall_only_when_blocked, clock, reset, !req_ready, rsp_valid && !rsp_ready && valid_ff[LAT-1])
   `GHU_ASSERT_NEXT(a_stall_holds_valids, clock, reset, !pipe_en, $stable(valid_ff))
   `GHU_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_valid && req_ready, valid_ff[0])
   `GHU_ASSERT_IMPL(a_short_form_bound, clock, reset, rsp_valid && rsp_short_form_used, rsp_distance_mm[34:30] == 5'd0)

endmodule
